// ----- rtl/wnn_pkg.sv -----
// ============================================================================
// Weighted nearest neighbor package
// Shared constants, function codes, register indexes, sequencer states and
// the structures that pass between the store, sequencer and datapath.
// ============================================================================
`default_nettype none

package wnn_pkg;

    // Table sizes and the index widths that follow from them.
    localparam int MAX_ENTRIES    = 256;
    localparam int MAX_COMPONENTS = 64;
    localparam int ENTRY_W        = $clog2(MAX_ENTRIES);
    localparam int COMP_W         = $clog2(MAX_COMPONENTS);
    localparam int TRAIN_AW       = ENTRY_W + COMP_W;
    localparam int TRAIN_DEPTH    = MAX_ENTRIES * MAX_COMPONENTS;

    // Field and datapath widths.
    localparam int FUNC_W   = 2;
    localparam int EFIELD_W = 8;
    localparam int CFIELD_W = 6;
    localparam int DATA_W   = 32;
    localparam int WEIGHT_W = 31;
    localparam int MAG_W    = 32;
    localparam int SQ_W     = 64;
    localparam int PROD_W   = 63;
    localparam int DIST_W   = 64;
    localparam int ECOUNT_W = 9;
    localparam int CCOUNT_W = 7;

    // Function codes carried in tuser.
    localparam logic [FUNC_W-1:0] FUNC_TRAIN  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_WEIGHT = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_TEST   = 2'd2;

    // Configuration register indexes (paddr bit 2).
    localparam logic REG_ENTRY_COUNT     = 1'b0;
    localparam logic REG_COMPONENT_COUNT = 1'b1;

    // Search sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_DRAIN,
        ST_FINISH
    } seq_state_t;

    // Write command into the stores, decoded from one input transaction.
    typedef struct packed {
        logic                train_we;
        logic                weight_we;
        logic                test_we;
        logic [ENTRY_W-1:0]  entry;
        logic [COMP_W-1:0]   comp;
        logic [DATA_W-1:0]   data;
    } store_wr_t;

    // Read command into the stores.
    typedef struct packed {
        logic                re;
        logic [ENTRY_W-1:0]  entry;
        logic [COMP_W-1:0]   comp;
    } store_rd_t;

    // Tag that travels with each component term down the datapath.
    typedef struct packed {
        logic                valid;
        logic                first;
        logic                last_comp;
        logic                final_item;
        logic [ENTRY_W-1:0]  entry;
    } term_tag_t;

    // 64-bit unsigned add that saturates at all ones.
    function automatic logic [DIST_W-1:0] sat_add(input logic [DIST_W-1:0] a,
                                                  input logic [DIST_W-1:0] b);
        logic [DIST_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[DIST_W] ? {DIST_W{1'b1}} : s[DIST_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ----- rtl/wnn_store.sv -----
// ============================================================================
// Weighted nearest neighbor stores
// Training, weight and test vector memories, each with one write port and
// one synchronous read port with registered read data.
// ============================================================================
`default_nettype none

module wnn_store (
    input  wire logic                       aclk,
    input  wire wnn_pkg::store_wr_t         wr,
    input  wire wnn_pkg::store_rd_t         rd,
    output logic [wnn_pkg::DATA_W-1:0]      train_q,
    output logic [wnn_pkg::DATA_W-1:0]      weight_q,
    output logic [wnn_pkg::DATA_W-1:0]      test_q
);

    logic [wnn_pkg::DATA_W-1:0] train_mem  [wnn_pkg::TRAIN_DEPTH];
    logic [wnn_pkg::DATA_W-1:0] weight_mem [wnn_pkg::MAX_COMPONENTS];
    logic [wnn_pkg::DATA_W-1:0] test_mem   [wnn_pkg::MAX_COMPONENTS];

    logic [wnn_pkg::TRAIN_AW-1:0] wr_train_addr;
    logic [wnn_pkg::TRAIN_AW-1:0] rd_train_addr;

    // Training entries are laid out entry-major, one row per entry.
    assign wr_train_addr = {wr.entry, wr.comp};
    assign rd_train_addr = {rd.entry, rd.comp};

    // Write ports.
    always_ff @(posedge aclk) begin
        if (wr.train_we) begin
            train_mem[wr_train_addr] <= wr.data;
        end
        if (wr.weight_we) begin
            weight_mem[wr.comp] <= wr.data;
        end
        if (wr.test_we) begin
            test_mem[wr.comp] <= wr.data;
        end
    end

    // Read ports with registered data.
    always_ff @(posedge aclk) begin
        if (rd.re) begin
            train_q  <= train_mem[rd_train_addr];
            weight_q <= weight_mem[rd.comp];
            test_q   <= test_mem[rd.comp];
        end
    end

endmodule

`default_nettype wire

// ----- rtl/wnn_seq.sv -----
// ============================================================================
// Weighted nearest neighbor search sequencer
// Steps through every entry and component of a search, one memory read per
// cycle, and hands the result to the output register when the search ends.
// ============================================================================
`default_nettype none

module wnn_seq (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          start,
    input  wire logic [wnn_pkg::ENTRY_W-1:0]   ne_m1,
    input  wire logic [wnn_pkg::COMP_W-1:0]    nc_m1,
    input  wire logic                          done,
    input  wire logic                          out_ready,
    output logic                               in_ready,
    output logic                               load_out,
    output wnn_pkg::store_rd_t                 rd,
    output wnn_pkg::term_tag_t                 tag
);

    wnn_pkg::seq_state_t state_reg, state_next;

    logic [wnn_pkg::ENTRY_W-1:0] entry_reg, entry_next;
    logic [wnn_pkg::COMP_W-1:0]  comp_reg,  comp_next;
    logic                        issue;
    logic                        last_comp;
    logic                        last_issue;

    assign last_comp  = (comp_reg == nc_m1);
    assign last_issue = last_comp && (entry_reg == ne_m1);

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            wnn_pkg::ST_IDLE: begin
                if (start) begin
                    state_next = wnn_pkg::ST_SEARCH;
                end
            end
            wnn_pkg::ST_SEARCH: begin
                if (last_issue) begin
                    state_next = wnn_pkg::ST_DRAIN;
                end
            end
            wnn_pkg::ST_DRAIN: begin
                if (done) begin
                    state_next = wnn_pkg::ST_FINISH;
                end
            end
            wnn_pkg::ST_FINISH: begin
                if (out_ready) begin
                    state_next = wnn_pkg::ST_IDLE;
                end
            end
            default: state_next = wnn_pkg::ST_IDLE;
        endcase
    end

    // State outputs.
    always_comb begin
        in_ready = 1'b0;
        issue    = 1'b0;
        load_out = 1'b0;
        unique case (state_reg)
            wnn_pkg::ST_IDLE:   in_ready = 1'b1;
            wnn_pkg::ST_SEARCH: issue    = 1'b1;
            wnn_pkg::ST_DRAIN:  ;
            wnn_pkg::ST_FINISH: load_out = out_ready;
            default:            ;
        endcase
    end

    // Read command and the tag that follows it.
    always_comb begin
        rd.re          = issue;
        rd.entry       = entry_reg;
        rd.comp        = comp_reg;
        tag.valid      = issue;
        tag.first      = (comp_reg == '0);
        tag.last_comp  = last_comp;
        tag.final_item = last_issue;
        tag.entry      = entry_reg;
    end

    // Entry and component counters.
    always_comb begin
        entry_next = entry_reg;
        comp_next  = comp_reg;
        if (start && (state_reg == wnn_pkg::ST_IDLE)) begin
            entry_next = '0;
            comp_next  = '0;
        end else if (issue) begin
            if (last_comp) begin
                comp_next  = '0;
                entry_next = entry_reg + wnn_pkg::ENTRY_W'(1);
            end else begin
                comp_next = comp_reg + wnn_pkg::COMP_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= wnn_pkg::ST_IDLE;
            entry_reg <= '0;
            comp_reg  <= '0;
        end else begin
            state_reg <= state_next;
            entry_reg <= entry_next;
            comp_reg  <= comp_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/wnn_dist.sv -----
// ============================================================================
// Weighted nearest neighbor distance datapath
// Pipeline from store read data to the weighted squared term, the per-entry
// saturating sum and the running minimum over entries.
// ============================================================================
`default_nettype none

module wnn_dist (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire wnn_pkg::term_tag_t            tag_in,
    input  wire logic [wnn_pkg::DATA_W-1:0]    train_q,
    input  wire logic [wnn_pkg::DATA_W-1:0]    weight_q,
    input  wire logic [wnn_pkg::DATA_W-1:0]    test_q,
    output logic [wnn_pkg::ENTRY_W-1:0]        best_index,
    output logic [wnn_pkg::DIST_W-1:0]         best_distance,
    output logic                               done
);

    localparam int DIFF_W = wnn_pkg::DATA_W + 1;

    // Tags, one per stage; tag 1 lines up with the memory read data.
    wnn_pkg::term_tag_t t1_reg, t2_reg, t3_reg, t4_reg, t5_reg, t6_reg;

    logic signed [DIFF_W-1:0]        diff;
    logic [DIFF_W-1:0]               diff_abs;
    logic [wnn_pkg::MAG_W-1:0]       mag_reg;
    logic [wnn_pkg::WEIGHT_W-1:0]    w2_reg, w3_reg;
    logic [wnn_pkg::SQ_W-1:0]        sq_reg;
    logic [wnn_pkg::PROD_W-1:0]      hi_reg, lo_reg;
    logic [wnn_pkg::DIST_W:0]        term_sum;
    logic                            term_sat;
    logic [wnn_pkg::DIST_W-1:0]      term_reg, term_next;
    logic [wnn_pkg::DIST_W-1:0]      acc_reg, acc_next;
    logic [wnn_pkg::ENTRY_W-1:0]     best_index_reg;
    logic [wnn_pkg::DIST_W-1:0]      best_dist_reg;
    logic                            done_reg;
    logic                            take_best;

    // Tag valid bits and the done flag are the only reset state in the pipe; the other tag
    // fields follow along without reset.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            t1_reg.valid <= 1'b0;
            t2_reg.valid <= 1'b0;
            t3_reg.valid <= 1'b0;
            t4_reg.valid <= 1'b0;
            t5_reg.valid <= 1'b0;
            t6_reg.valid <= 1'b0;
            done_reg     <= 1'b0;
        end else begin
            t1_reg.valid <= tag_in.valid;
            t2_reg.valid <= t1_reg.valid;
            t3_reg.valid <= t2_reg.valid;
            t4_reg.valid <= t3_reg.valid;
            t5_reg.valid <= t4_reg.valid;
            t6_reg.valid <= t5_reg.valid;
            done_reg     <= t6_reg.valid && t6_reg.last_comp && t6_reg.final_item;
        end
        t1_reg.first      <= tag_in.first;
        t1_reg.last_comp  <= tag_in.last_comp;
        t1_reg.final_item <= tag_in.final_item;
        t1_reg.entry      <= tag_in.entry;
        t2_reg.first      <= t1_reg.first;
        t2_reg.last_comp  <= t1_reg.last_comp;
        t2_reg.final_item <= t1_reg.final_item;
        t2_reg.entry      <= t1_reg.entry;
        t3_reg.first      <= t2_reg.first;
        t3_reg.last_comp  <= t2_reg.last_comp;
        t3_reg.final_item <= t2_reg.final_item;
        t3_reg.entry      <= t2_reg.entry;
        t4_reg.first      <= t3_reg.first;
        t4_reg.last_comp  <= t3_reg.last_comp;
        t4_reg.final_item <= t3_reg.final_item;
        t4_reg.entry      <= t3_reg.entry;
        t5_reg.first      <= t4_reg.first;
        t5_reg.last_comp  <= t4_reg.last_comp;
        t5_reg.final_item <= t4_reg.final_item;
        t5_reg.entry      <= t4_reg.entry;
        t6_reg.first      <= t5_reg.first;
        t6_reg.last_comp  <= t5_reg.last_comp;
        t6_reg.final_item <= t5_reg.final_item;
        t6_reg.entry      <= t5_reg.entry;
    end

    // Exact difference and its magnitude; the magnitude always fits 32 bits.
    always_comb begin
        diff     = $signed({test_q[wnn_pkg::DATA_W-1], test_q})
                 - $signed({train_q[wnn_pkg::DATA_W-1], train_q});
        diff_abs = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
    end

    // Weighted term: a 64-bit square times a 31-bit weight, split in halves.
    always_comb begin
        term_sum  = {1'b0, hi_reg[47:0], 16'b0} + (wnn_pkg::DIST_W + 1)'(lo_reg[62:16]);
        term_sat  = (hi_reg[62:48] != '0) || term_sum[wnn_pkg::DIST_W];
        term_next = term_sat ? {wnn_pkg::DIST_W{1'b1}} : term_sum[wnn_pkg::DIST_W-1:0];
    end

    // Per-entry saturating sum; the first component restarts it.
    always_comb begin
        acc_next = wnn_pkg::sat_add(t5_reg.first ? '0 : acc_reg, term_reg);
    end

    // Arithmetic stages.
    always_ff @(posedge aclk) begin
        mag_reg  <= diff_abs[wnn_pkg::MAG_W-1:0];
        w2_reg   <= weight_q[wnn_pkg::WEIGHT_W-1:0];
        sq_reg   <= mag_reg * mag_reg;
        w3_reg   <= w2_reg;
        hi_reg   <= sq_reg[63:32] * w3_reg;
        lo_reg   <= sq_reg[31:0] * w3_reg;
        term_reg <= term_next;
        if (t5_reg.valid) begin
            acc_reg <= acc_next;
        end
    end

    // Running minimum; strict less keeps the lowest index on a tie.
    assign take_best = t6_reg.valid && t6_reg.last_comp &&
                       ((t6_reg.entry == '0) || (acc_reg < best_dist_reg));

    always_ff @(posedge aclk) begin
        if (take_best) begin
            best_index_reg <= t6_reg.entry;
            best_dist_reg  <= acc_reg;
        end
    end

    assign best_index    = best_index_reg;
    assign best_distance = best_dist_reg;
    assign done          = done_reg;

endmodule

`default_nettype wire

// ----- rtl/weighted_nearest_neighbor_unit.sv -----
// ============================================================================
// Weighted nearest neighbor unit
// Stores training projection vectors and per-component weights, and on the
// last test vector element returns the training entry of smallest weighted
// squared distance together with that distance.
// ============================================================================
// Load transactions (training coefficients, weights and test elements) are
// taken one per cycle while s_tready is high. A test element with tlast set
// stores its value and then starts a search: the single read port of the
// training memory visits one component of one entry per cycle, and the
// result then passes through the pipeline to the output register. During the
// search s_tready is low. Loads are taken again while a finished result waits
// on the output channel. The memories come out of reset unwritten and need no
// clearing; entries that a search reads must have been loaded first.
`default_nettype none

module weighted_nearest_neighbor_unit (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // Input stream.
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [47:0] s_tdata,   // entry[7:0], component[13:8], value[45:14], zero pad
    input  wire logic [1:0]  s_tuser,   // func[1:0]
    input  wire logic        s_tlast,
    // Result stream.
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [71:0]      m_tdata,   // nearest_index[7:0], best_distance[71:8]
    // Configuration port.
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    logic [wnn_pkg::ECOUNT_W-1:0] entry_count_reg;
    logic [wnn_pkg::CCOUNT_W-1:0] component_count_reg;
    logic [wnn_pkg::ENTRY_W-1:0]  ne_m1;
    logic [wnn_pkg::COMP_W-1:0]   nc_m1;
    logic                         cfg_write;

    logic [wnn_pkg::EFIELD_W-1:0] s_entry;
    logic [wnn_pkg::CFIELD_W-1:0] s_component;
    logic [wnn_pkg::DATA_W-1:0]   s_value;
    logic                         s_accept;
    logic                         entry_ok;
    logic                         comp_ok;
    logic                         start;

    wnn_pkg::store_wr_t           wr;
    wnn_pkg::store_rd_t           rd;
    wnn_pkg::term_tag_t           tag;
    logic [wnn_pkg::DATA_W-1:0]   train_q;
    logic [wnn_pkg::DATA_W-1:0]   weight_q;
    logic [wnn_pkg::DATA_W-1:0]   test_q;
    logic [wnn_pkg::ENTRY_W-1:0]  best_index;
    logic [wnn_pkg::DIST_W-1:0]   best_distance;
    logic                         done;
    logic                         out_ready;
    logic                         load_out;
    logic                         in_ready;

    logic                         m_tvalid_reg;
    logic [wnn_pkg::EFIELD_W-1:0] m_index_reg;
    logic [wnn_pkg::DIST_W-1:0]   m_dist_reg;

    // Configuration registers.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            entry_count_reg     <= wnn_pkg::ECOUNT_W'(1);
            component_count_reg <= wnn_pkg::CCOUNT_W'(1);
        end else if (cfg_write) begin
            unique case (paddr[2])
                wnn_pkg::REG_ENTRY_COUNT:
                    entry_count_reg <= pwdata[wnn_pkg::ECOUNT_W-1:0];
                wnn_pkg::REG_COMPONENT_COUNT:
                    component_count_reg <= pwdata[wnn_pkg::CCOUNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            wnn_pkg::REG_ENTRY_COUNT:     prdata = 32'(entry_count_reg);
            wnn_pkg::REG_COMPONENT_COUNT: prdata = 32'(component_count_reg);
            default:                      prdata = '0;
        endcase
    end

    // Counts clamped into their legal ranges, kept as last index.
    always_comb begin
        if (entry_count_reg == '0) begin
            ne_m1 = '0;
        end else if (int'(entry_count_reg) > wnn_pkg::MAX_ENTRIES) begin
            ne_m1 = wnn_pkg::ENTRY_W'(wnn_pkg::MAX_ENTRIES - 1);
        end else begin
            ne_m1 = wnn_pkg::ENTRY_W'(entry_count_reg - wnn_pkg::ECOUNT_W'(1));
        end
        if (component_count_reg == '0) begin
            nc_m1 = '0;
        end else if (int'(component_count_reg) > wnn_pkg::MAX_COMPONENTS) begin
            nc_m1 = wnn_pkg::COMP_W'(wnn_pkg::MAX_COMPONENTS - 1);
        end else begin
            nc_m1 = wnn_pkg::COMP_W'(component_count_reg - wnn_pkg::CCOUNT_W'(1));
        end
    end

    // Input transaction decode into store writes.
    assign s_entry     = s_tdata[7:0];
    assign s_component = s_tdata[13:8];
    assign s_value     = s_tdata[45:14];
    assign s_tready    = in_ready;
    assign s_accept    = s_tvalid && s_tready;
    assign entry_ok    = int'(s_entry) < wnn_pkg::MAX_ENTRIES;
    assign comp_ok     = int'(s_component) < wnn_pkg::MAX_COMPONENTS;
    assign start       = s_accept && (s_tuser == wnn_pkg::FUNC_TEST) && s_tlast;

    always_comb begin
        wr.train_we  = s_accept && (s_tuser == wnn_pkg::FUNC_TRAIN) && entry_ok && comp_ok;
        wr.weight_we = s_accept && (s_tuser == wnn_pkg::FUNC_WEIGHT) && comp_ok;
        wr.test_we   = s_accept && (s_tuser == wnn_pkg::FUNC_TEST) && comp_ok;
        wr.entry     = s_entry[wnn_pkg::ENTRY_W-1:0];
        wr.comp      = s_component[wnn_pkg::COMP_W-1:0];
        // Negative weights are stored as zero.
        if ((s_tuser == wnn_pkg::FUNC_WEIGHT) && s_value[wnn_pkg::DATA_W-1]) begin
            wr.data = '0;
        end else begin
            wr.data = s_value;
        end
    end

    wnn_store u_store (
        .aclk     (aclk),
        .wr       (wr),
        .rd       (rd),
        .train_q  (train_q),
        .weight_q (weight_q),
        .test_q   (test_q)
    );

    wnn_seq u_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (start),
        .ne_m1     (ne_m1),
        .nc_m1     (nc_m1),
        .done      (done),
        .out_ready (out_ready),
        .in_ready  (in_ready),
        .load_out  (load_out),
        .rd        (rd),
        .tag       (tag)
    );

    wnn_dist u_dist (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .tag_in        (tag),
        .train_q       (train_q),
        .weight_q      (weight_q),
        .test_q        (test_q),
        .best_index    (best_index),
        .best_distance (best_distance),
        .done          (done)
    );

    // Output register; the slot frees when the downstream side takes it.
    assign out_ready = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (load_out) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_out) begin
            m_index_reg <= wnn_pkg::EFIELD_W'(best_index);
            m_dist_reg  <= best_distance;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {m_dist_reg, m_index_reg};

endmodule

`default_nettype wire

// ----- rtl/wnn_checker.sv -----
// ============================================================================
// Weighted nearest neighbor port checker
// Watches the top level's ports for result stream, search and register rules,
// and is bound to every instance of the top level.
// ============================================================================
`default_nettype none

module wnn_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic [1:0]  s_tuser,
    input wire logic        s_tlast,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [71:0] m_tdata,
    input wire logic        psel,
    input wire logic        pwrite,
    input wire logic [2:0]  paddr,
    input wire logic [31:0] prdata
);

    // A stalled result transaction holds its data.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // The last test element starts a search, so input is held off next cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tlast && (s_tuser == wnn_pkg::FUNC_TEST)
        |=> !s_tready)
        else $error("input still ready after a search was started");

    // A result appears only at the end of a search, when input was held off.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("result appeared outside a search");

    // The component count reads back with no bits above its width.
    assert property (@(posedge aclk) disable iff (!aresetn)
        psel && !pwrite && (paddr[2] == wnn_pkg::REG_COMPONENT_COUNT)
        |-> (prdata[31:wnn_pkg::CCOUNT_W] == '0))
        else $error("component count read back out of range");

endmodule

bind weighted_nearest_neighbor_unit wnn_checker u_wnn_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .prdata   (prdata)
);

`default_nettype wire
